### rtl/core/sffa_pkg.sv
// sffa_pkg: shared constants and types for the segment first-fit allocator
// no dependencies
`default_nettype none
package sffa_pkg;
	localparam int SEGMENTS_DEF    = 64;
	localparam int MAX_EXTENTS_DEF = 32;

	typedef logic [1:0] action_t;
	typedef logic [2:0] status_t;

	localparam action_t ACT_ALLOC    = 2'd0;
	localparam action_t ACT_FREE     = 2'd1;
	localparam action_t ACT_FREE_ALL = 2'd2;
	localparam action_t ACT_UNUSED   = 2'd3;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_OOM     = 3'd1;
	localparam status_t ST_ZERO    = 3'd2;
	localparam status_t ST_OUTSIDE = 3'd3;
	localparam status_t ST_OVERLAP = 3'd4;
	localparam status_t ST_DOUBLE  = 3'd5;
endpackage
`default_nettype wire

### rtl/core/segment_first_fit_allocator.sv
// segment_first_fit_allocator: address-ordered free extent table in one memory
// depends on sffa_pkg
//
// usage: raise start with action, start_segment and seg_count while busy is
// low; the transfer happens at that edge and busy is high from the next cycle.
// the block walks the extent table held in a synchronous memory (one entry
// read per cycle, registered read data), applies the allocate or free,
// shifts entries up or down for inserts and removals, and then walks the
// table once more to gather the free total and the largest extent. the
// result is shown for one cycle with done high; the receiver cannot stall it
// and busy is already low in that cycle, so a new transfer may happen there.
// the search reads and then checks each entry that it visits, a shift reads
// and then writes each entry that it moves, and the summary pass and the
// output state follow; every step goes through the single read port. zero
// size and outside ram go straight to the summary pass. free everything
// runs a clearing pass and then the summary pass. after reset a clearing
// pass runs with busy high before the first transfer.
`default_nettype none
module segment_first_fit_allocator #(
	parameter int SEGMENTS    = sffa_pkg::SEGMENTS_DEF,
	parameter int MAX_EXTENTS = sffa_pkg::MAX_EXTENTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire sffa_pkg::action_t action,
	input  wire logic [5:0]       start_segment,
	input  wire logic [6:0]       seg_count,
	output logic                  done,
	output sffa_pkg::status_t     status,
	output logic [5:0]            granted_segment,
	output logic [6:0]            free_total,
	output logic [6:0]            largest_free,
	output logic                  ram_empty,
	output logic                  ram_full,
	output logic                  fragmented
);
	import sffa_pkg::*;

	localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);

	localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_CHK = 4'd3,
		S_UPRD = 4'd4, S_UPWR = 4'd5, S_DNRD = 4'd6, S_DNWR = 4'd7,
		S_SUMRD = 4'd8, S_SUMCHK = 4'd9, S_OUT = 4'd10, S_PREV = 4'd11,
		S_PREVCHK = 4'd12;

	// entry memory: {start, length}
	logic [15:0] mem [MAX_EXTENTS];
	logic [15:0] rdata;
	logic        we;
	logic [IW-1:0] waddr, raddr;
	logic [15:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;       // extent count
	logic [CW-1:0] idx_q;       // walk index
	logic [CW-1:0] tgt_q;       // target of insert or removal
	action_t       act_q;
	logic [7:0]    s_q, n_q;
	status_t       st_q;
	logic [5:0]    gr_q;
	logic [7:0]    tot_q, big_q, first_len_q;
	logic [15:0]   ins_q;       // entry written at the end of a shift up
	logic [7:0]    pe_q;        // end of preceding extent
	logic          has_prev_q;
	logic          mode_q;      // 1: after shift down, merge into tgt-1

	wire [7:0] ent_s = rdata[15:8];
	wire [7:0] ent_l = rdata[7:0];
	wire [7:0] e_end = s_q + n_q;
	wire [7:0] cur_end = ent_s + ent_l;

	assign busy = (state_q != S_IDLE);

	// memory port control: clearing, modify writes and shift moves
	always_comb begin
		we = 1'b0; waddr = idx_q[IW-1:0]; wdata = '0; raddr = idx_q[IW-1:0];
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wdata = (idx_q == '0) ? {8'd0, 8'(SEGMENTS)} : 16'd0;
			end
			S_CHK: begin
				if (act_q == ACT_ALLOC) begin
					if (ent_l > n_q) begin
						we = 1'b1; wdata = {ent_s, ent_l - n_q};
					end
				end else if (s_q < ent_s && e_end == ent_s &&
					!(has_prev_q && s_q <= pe_q)) begin
					we = 1'b1; wdata = {s_q, ent_l + n_q};
				end
			end
			S_PREVCHK: begin
				we = 1'b1; wdata = {ent_s, ent_l + n_q};
			end
			S_UPRD: raddr = IW'(idx_q - 1'b1);
			S_UPWR: begin
				we = 1'b1;
				wdata = (idx_q == tgt_q) ? ins_q : rdata;
			end
			S_DNWR: begin
				we = 1'b1; waddr = IW'(idx_q - 1'b1);
				wdata = (idx_q >= cnt_q) ? 16'd0 : rdata;
			end
			S_SUMCHK: raddr = IW'(idx_q + 1'b1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; idx_q <= '0; cnt_q <= '0; done <= 1'b0;
			tgt_q <= '0; act_q <= ACT_ALLOC; s_q <= '0; n_q <= '0;
			st_q <= ST_OK; gr_q <= '0; tot_q <= '0; big_q <= '0; first_len_q <= '0;
			ins_q <= '0; pe_q <= '0; has_prev_q <= 1'b0; mode_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (idx_q == CW'(MAX_EXTENTS - 1)) begin
						cnt_q <= CW'(1);
						idx_q <= '0;
						state_q <= (act_q == ACT_FREE_ALL && tgt_q == '1) ? S_SUMRD : S_IDLE;
					end else idx_q <= idx_q + 1'b1;
				end
				S_IDLE: if (start) begin
					act_q <= action; s_q <= {2'b0, start_segment}; n_q <= {1'b0, seg_count};
					st_q <= ST_OK; gr_q <= '0; idx_q <= '0; has_prev_q <= 1'b0; pe_q <= '0;
					tgt_q <= '0; mode_q <= 1'b0;
					if (action == ACT_FREE_ALL) begin
						tgt_q <= '1; act_q <= ACT_FREE_ALL; state_q <= S_CLEAR;
					end else if (action == ACT_ALLOC || action == ACT_FREE) begin
						if (seg_count == '0) begin
							st_q <= ST_ZERO; state_q <= S_SUMRD;
						end else if (action == ACT_FREE &&
							({2'b0, start_segment} + {1'b0, seg_count}) > 8'(SEGMENTS)) begin
							st_q <= ST_OUTSIDE; state_q <= S_SUMRD;
						end else state_q <= S_RD;
					end else state_q <= S_SUMRD;
				end
				S_RD: begin
					// reached end of table
					if (idx_q >= cnt_q) begin
						if (act_q == ACT_ALLOC) begin
							st_q <= ST_OOM; state_q <= S_SUMRD; idx_q <= '0;
						end else if (has_prev_q && s_q == pe_q) begin
							idx_q <= idx_q - 1'b1; state_q <= S_PREV;
						end else if (!has_prev_q || s_q > pe_q) begin
							if (cnt_q >= CW'(MAX_EXTENTS)) begin
								st_q <= ST_OOM; state_q <= S_SUMRD; idx_q <= '0;
							end else begin
								tgt_q <= idx_q; ins_q <= {s_q, n_q}; state_q <= S_UPRD;
								idx_q <= cnt_q;
							end
						end else begin
							st_q <= ST_DOUBLE; state_q <= S_SUMRD; idx_q <= '0;
						end
					end else state_q <= S_CHK;
				end
				S_CHK: begin
					if (act_q == ACT_ALLOC) begin
						if (ent_l >= n_q) begin
							if (ent_l > n_q) begin
								gr_q <= 6'(ent_s + ent_l - n_q);
								state_q <= S_SUMRD; idx_q <= '0;
							end else begin
								gr_q <= ent_s[5:0]; tgt_q <= idx_q; mode_q <= 1'b0;
								idx_q <= idx_q + 1'b1; state_q <= S_DNRD;
							end
						end else begin
							idx_q <= idx_q + 1'b1; state_q <= S_RD;
						end
					end else if (s_q >= ent_s) begin
						has_prev_q <= 1'b1; pe_q <= cur_end;
						idx_q <= idx_q + 1'b1; state_q <= S_RD;
					end else begin
						// current extent found at idx_q
						state_q <= S_SUMRD;
						if (has_prev_q && s_q == pe_q) begin
							if (e_end < ent_s) begin
								idx_q <= idx_q - 1'b1; state_q <= S_PREV;
							end else if (e_end == ent_s) begin
								// merge three ways: prev += n + cur, drop cur
								n_q <= n_q + ent_l; tgt_q <= idx_q; mode_q <= 1'b1;
								idx_q <= idx_q + 1'b1; state_q <= S_DNRD;
							end else begin
								st_q <= ST_OVERLAP; idx_q <= '0;
							end
						end else if (e_end == ent_s) begin
							// grow the current extent downward, written by the port control
							if (has_prev_q && s_q < pe_q) st_q <= ST_OVERLAP;
							idx_q <= '0;
						end else if (e_end > ent_s) begin
							st_q <= ST_OVERLAP; idx_q <= '0;
						end else if (!has_prev_q || s_q > pe_q) begin
							if (cnt_q >= CW'(MAX_EXTENTS)) begin
								st_q <= ST_OOM; idx_q <= '0;
							end else begin
								tgt_q <= idx_q; ins_q <= {s_q, n_q}; idx_q <= cnt_q;
								state_q <= S_UPRD;
							end
						end else begin
							st_q <= ST_DOUBLE; idx_q <= '0;
						end
					end
				end
				// grow the preceding extent by n
				S_PREV: state_q <= S_PREVCHK;
				S_PREVCHK: begin
					idx_q <= '0; state_q <= S_SUMRD;
				end
				// shift up: entry idx-1 moves to idx, from the top down to tgt
				S_UPRD: state_q <= S_UPWR;
				S_UPWR: begin
					if (idx_q == tgt_q) begin
						cnt_q <= cnt_q + 1'b1; idx_q <= '0; state_q <= S_SUMRD;
					end else begin
						idx_q <= idx_q - 1'b1; state_q <= S_UPRD;
					end
				end
				// shift down: entry idx moves to idx-1, clearing the last slot
				S_DNRD: state_q <= S_DNWR;
				S_DNWR: begin
					if (idx_q >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						if (mode_q) begin
							idx_q <= tgt_q - 1'b1; state_q <= S_PREV;
						end else begin
							idx_q <= '0; state_q <= S_SUMRD;
						end
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= S_DNRD;
					end
				end
				// summary pass over the table
				S_SUMRD: begin
					tot_q <= '0; big_q <= '0; first_len_q <= '0;
					if (cnt_q == '0) state_q <= S_OUT;
					else state_q <= S_SUMCHK;
				end
				S_SUMCHK: begin
					tot_q <= tot_q + ent_l;
					if (ent_l > big_q) big_q <= ent_l;
					if (idx_q == '0) first_len_q <= ent_l;
					if (idx_q + 1'b1 >= cnt_q) state_q <= S_OUT;
					else idx_q <= idx_q + 1'b1;
				end
				S_OUT: begin
					done <= 1'b1; tgt_q <= '0; act_q <= ACT_ALLOC; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			status <= st_q;
			granted_segment <= (act_q == ACT_ALLOC && st_q == ST_OK) ? gr_q : 6'd0;
			free_total <= tot_q[6:0];
			largest_free <= big_q[6:0];
			ram_empty <= (cnt_q != '0) && (first_len_q == 8'(SEGMENTS));
			ram_full <= (cnt_q == '0);
			fragmented <= (cnt_q > CW'(1));
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_EXTENTS)) else $error("extent count out of range");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not go busy");
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_DOUBLE)) else $error("bad status code");
endmodule
`default_nettype wire
